// ===== design/eswt_pkg.sv =====
// Shared types, widths and constants for the energy-sum window trigger.
package eswt_pkg;

  localparam int POSITION_BITS = 24;
  localparam int ENERGY_BITS   = 32;
  localparam int SUM_BITS      = 40;

  localparam int TIME_BITS   = 32;
  localparam int STATUS_BITS = 8;
  localparam int TYPE_BITS   = 32;
  localparam int HW_BITS     = 22;
  localparam int HH_BITS     = 23;
  localparam int LEN_BITS    = 23;
  localparam int THR_BITS    = 32;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;

  // Box compares: twice the half width needs HW_BITS+1 magnitude bits.
  localparam int BOX_MAG_BITS = (HW_BITS + 1 > HH_BITS) ?
                                ((HW_BITS + 1 > LEN_BITS) ? HW_BITS + 1 : LEN_BITS) :
                                ((HH_BITS > LEN_BITS) ? HH_BITS : LEN_BITS);
  localparam int BOX_W = ((POSITION_BITS > BOX_MAG_BITS + 1) ?
                          POSITION_BITS : BOX_MAG_BITS + 1) + 1;

  // Accumulator: sum plus a signed energy difference, one bit of headroom.
  localparam int ACC_W = ((SUM_BITS > ENERGY_BITS + 1) ? SUM_BITS : ENERGY_BITS + 1) + 1;
  localparam int TRG_W = ((SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS) + 1;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  localparam logic [STATUS_BITS-1:0] STATUS_STABLE = 8'd1;

  localparam logic signed [TYPE_BITS-1:0] TYPE_ELECTRON = 32'sd11;
  localparam logic signed [TYPE_BITS-1:0] TYPE_MUON     = 32'sd13;
  localparam logic signed [TYPE_BITS-1:0] TYPE_PION     = 32'sd211;
  localparam logic signed [TYPE_BITS-1:0] TYPE_KAON     = 32'sd321;
  localparam logic signed [TYPE_BITS-1:0] TYPE_PROTON   = 32'sd2212;

  localparam logic signed [TIME_BITS-1:0] RST_TIME_MIN = 32'sd0;
  localparam logic signed [TIME_BITS-1:0] RST_TIME_MAX = 32'sd2000;
  localparam logic [HW_BITS-1:0]          RST_HW       = 22'd2000;
  localparam logic [HH_BITS-1:0]          RST_HH       = 23'd2000;
  localparam logic [LEN_BITS-1:0]         RST_LEN      = 23'd5000;
  localparam logic [THR_BITS-1:0]         RST_THR      = 32'd100000;

  typedef enum logic [2:0] {
    REG_TIME_MIN    = 3'd0,
    REG_TIME_MAX    = 3'd1,
    REG_HALF_WIDTH  = 3'd2,
    REG_HALF_HEIGHT = 3'd3,
    REG_LENGTH      = 3'd4,
    REG_THRESHOLD   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                            end_only;
    logic                            first_point;
    logic signed [TIME_BITS-1:0]     particle_time_ns;
    logic [STATUS_BITS-1:0]          status_code;
    logic signed [TYPE_BITS-1:0]     type_code;
    logic signed [POSITION_BITS-1:0] pos_x_mm;
    logic signed [POSITION_BITS-1:0] pos_y_mm;
    logic signed [POSITION_BITS-1:0] pos_z_mm;
    logic [ENERGY_BITS-1:0]          energy_kev;
    logic                            last_in_event;
  } in_item_t;

  typedef struct packed {
    logic                       trigger;
    logic signed [SUM_BITS-1:0] deposit_kev;
  } out_item_t;

  typedef struct packed {
    logic signed [TIME_BITS-1:0] time_min_ns;
    logic signed [TIME_BITS-1:0] time_max_ns;
    logic [HW_BITS-1:0]          half_width_mm;
    logic [HH_BITS-1:0]          half_height_mm;
    logic [LEN_BITS-1:0]         length_mm;
    logic [THR_BITS-1:0]         threshold_kev;
  } cfg_regs_t;

  typedef struct packed {
    logic qualify;
    logic in_box;
  } pt_flags_t;

endpackage

// ===== design/eswt_point_check.sv =====
// Particle qualification and detector box tests for one incoming point.
module eswt_point_check (
  input  eswt_pkg::in_item_t  item,
  input  eswt_pkg::cfg_regs_t cfg,
  output eswt_pkg::pt_flags_t flags
);

  logic                              time_ok;
  logic                              type_ok;
  logic signed [eswt_pkg::BOX_W-1:0] x_s, y_s, z_s;
  logic signed [eswt_pkg::BOX_W-1:0] x_lim, y_lim, z_lim;

  assign time_ok = (item.particle_time_ns >= cfg.time_min_ns) &&
                   (item.particle_time_ns <= cfg.time_max_ns);

  assign type_ok = (item.type_code == eswt_pkg::TYPE_ELECTRON) ||
                   (item.type_code == eswt_pkg::TYPE_MUON) ||
                   (item.type_code == eswt_pkg::TYPE_PION) ||
                   (item.type_code == eswt_pkg::TYPE_KAON) ||
                   (item.type_code == eswt_pkg::TYPE_PROTON);

  // sign-extend positions, zero-extend limits
  assign x_s   = eswt_pkg::BOX_W'(item.pos_x_mm);
  assign y_s   = eswt_pkg::BOX_W'(item.pos_y_mm);
  assign z_s   = eswt_pkg::BOX_W'(item.pos_z_mm);
  assign x_lim = signed'(eswt_pkg::BOX_W'({cfg.half_width_mm, 1'b0}));
  assign y_lim = signed'(eswt_pkg::BOX_W'(cfg.half_height_mm));
  assign z_lim = signed'(eswt_pkg::BOX_W'(cfg.length_mm));

  assign flags.qualify = time_ok && type_ok && (item.status_code == eswt_pkg::STATUS_STABLE);
  // z lower bound: sign bit clear
  assign flags.in_box  = (x_s >= -x_lim) && (x_s <= x_lim) &&
                         (y_s >= -y_lim) && (y_s <= y_lim) &&
                         !z_s[eswt_pkg::BOX_W-1] && (z_s <= z_lim);

endmodule

// ===== design/energy_sum_window_trigger_top.sv =====
// Top level of the energy-sum window trigger: config registers, point stage, accumulator.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): one trajectory point per transaction.
//   first_point qualifies a particle (time window, stable status, type code);
//   later points of a qualified particle inside the box add prev minus current
//   energy to a saturating 40-bit signed sum. end_only items carry no point.
//   An item with last_in_event set produces one result transaction on the
//   output channel (out_valid/out_ready/out_data): the sum and trigger
//   (sum > threshold_kev). The per-event state then clears.
//   Config: APB-style port, six registers at byte offsets 0x00..0x14, write on
//   psel & penable & pwrite, pready tied high, reads return register values.
//   Write config only while no items are in flight.
// Timing:
//   Point tests are done before the input register; the accumulator update
//   and trigger compare sit between the input register and the result register.
//   One item per cycle sustained while no result is held by out_ready. out_valid
//   rises when the last item of its event leaves the input register.
// Reset (rst_n, synchronous, low): both stages empty, per-event state zero,
//   registers at their defaults.
// Stall: a held result keeps out_data stable; one more item may wait in the
//   input register, and in_ready drops only if that item also ends an event.
module energy_sum_window_trigger_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  eswt_pkg::in_item_t                 in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output eswt_pkg::out_item_t                out_data,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [eswt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [eswt_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [eswt_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  // ---------------- configuration registers ----------------
  eswt_pkg::cfg_regs_t  cfg_r;
  eswt_pkg::reg_idx_t   reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = eswt_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_min_ns    <= eswt_pkg::RST_TIME_MIN;
      cfg_r.time_max_ns    <= eswt_pkg::RST_TIME_MAX;
      cfg_r.half_width_mm  <= eswt_pkg::RST_HW;
      cfg_r.half_height_mm <= eswt_pkg::RST_HH;
      cfg_r.length_mm      <= eswt_pkg::RST_LEN;
      cfg_r.threshold_kev  <= eswt_pkg::RST_THR;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        eswt_pkg::REG_TIME_MIN:    cfg_r.time_min_ns    <= signed'(pwdata);
        eswt_pkg::REG_TIME_MAX:    cfg_r.time_max_ns    <= signed'(pwdata);
        eswt_pkg::REG_HALF_WIDTH:  cfg_r.half_width_mm  <= pwdata[eswt_pkg::HW_BITS-1:0];
        eswt_pkg::REG_HALF_HEIGHT: cfg_r.half_height_mm <= pwdata[eswt_pkg::HH_BITS-1:0];
        eswt_pkg::REG_LENGTH:      cfg_r.length_mm      <= pwdata[eswt_pkg::LEN_BITS-1:0];
        eswt_pkg::REG_THRESHOLD:   cfg_r.threshold_kev  <= pwdata[eswt_pkg::THR_BITS-1:0];
        default: ;  // unmapped offsets ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eswt_pkg::REG_TIME_MIN:    prdata = unsigned'(cfg_r.time_min_ns);
      eswt_pkg::REG_TIME_MAX:    prdata = unsigned'(cfg_r.time_max_ns);
      eswt_pkg::REG_HALF_WIDTH:  prdata = eswt_pkg::APB_DATA_BITS'(cfg_r.half_width_mm);
      eswt_pkg::REG_HALF_HEIGHT: prdata = eswt_pkg::APB_DATA_BITS'(cfg_r.half_height_mm);
      eswt_pkg::REG_LENGTH:      prdata = eswt_pkg::APB_DATA_BITS'(cfg_r.length_mm);
      eswt_pkg::REG_THRESHOLD:   prdata = eswt_pkg::APB_DATA_BITS'(cfg_r.threshold_kev);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  eswt_pkg::pt_flags_t          pt_flags;
  logic                         s1_valid_r;
  logic                         s1_end_only_r;
  logic                         s1_first_r;
  logic                         s1_last_r;
  eswt_pkg::pt_flags_t          s1_flags_r;
  logic [eswt_pkg::ENERGY_BITS-1:0] s1_energy_r;
  logic                         s1_fire;
  logic                         out_free;
  logic                         in_fire;

  eswt_point_check u_point_check (
    .item  (in_data),
    .cfg   (cfg_r),
    .flags (pt_flags)
  );

  // an item without event end never needs the result register
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_end_only_r <= in_data.end_only;
      s1_first_r    <= in_data.first_point;
      s1_last_r     <= in_data.last_in_event;
      s1_flags_r    <= pt_flags;
      s1_energy_r   <= in_data.energy_kev;
    end
  end

  // ---------------- accumulator ----------------
  logic                                 qualified_r, qualified_nxt;
  logic [eswt_pkg::ENERGY_BITS-1:0]     prev_energy_r, prev_energy_nxt;
  logic signed [eswt_pkg::SUM_BITS-1:0] sum_r, sum_nxt, sum_evt;
  logic signed [eswt_pkg::ACC_W-1:0]    acc;
  logic                                 trig;

  // sum + prev - energy, full width, then clamp
  assign acc = eswt_pkg::ACC_W'(sum_r)
             + signed'(eswt_pkg::ACC_W'(prev_energy_r))
             - signed'(eswt_pkg::ACC_W'(s1_energy_r));

  always_comb begin
    qualified_nxt   = qualified_r;
    prev_energy_nxt = prev_energy_r;
    sum_evt         = sum_r;
    if (!s1_end_only_r) begin
      prev_energy_nxt = s1_energy_r;
      if (s1_first_r) begin
        qualified_nxt = s1_flags_r.qualify;
      end else if (qualified_r && s1_flags_r.in_box) begin
        priority if (acc > eswt_pkg::ACC_W'(eswt_pkg::SUM_MAX)) begin
          sum_evt = eswt_pkg::SUM_MAX;
        end else if (acc < eswt_pkg::ACC_W'(eswt_pkg::SUM_MIN)) begin
          sum_evt = eswt_pkg::SUM_MIN;
        end else begin
          sum_evt = acc[eswt_pkg::SUM_BITS-1:0];
        end
      end
    end
    sum_nxt = sum_evt;
    if (s1_last_r) begin
      qualified_nxt   = 1'b0;
      prev_energy_nxt = '0;
      sum_nxt         = '0;
    end
  end

  assign trig = eswt_pkg::TRG_W'(sum_evt) >
                signed'(eswt_pkg::TRG_W'(cfg_r.threshold_kev));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qualified_r   <= 1'b0;
      prev_energy_r <= '0;
      sum_r         <= '0;
    end else if (s1_fire) begin
      qualified_r   <= qualified_nxt;
      prev_energy_r <= prev_energy_nxt;
      sum_r         <= sum_nxt;
    end
  end

  // ---------------- result register ----------------
  logic                out_valid_r;
  eswt_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_data_r.trigger     <= trig;
      out_data_r.deposit_kev <= sum_evt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/eswt_checker.sv =====
// Port-level checks for the energy-sum window trigger, bound to the top level.
module eswt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input eswt_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input eswt_pkg::out_item_t out_data
);

  // held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only back-pressures when a result is blocked
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // threshold is non-negative, so a trigger needs a positive sum
  a_trig_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.trigger |->
      !out_data.deposit_kev[eswt_pkg::SUM_BITS-1] && (out_data.deposit_kev != '0))
    else $error("trigger set on non-positive sum");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind energy_sum_window_trigger_top eswt_checker u_eswt_checker (.*);
